// ===== hdl/bvsm_pkg.sv =====
// bvsm_pkg: codes, widths and constants for the banknote validator sequencer
// no dependencies; imported by bill_validator_state_machine_core
`default_nettype none
package bvsm_pkg;

    localparam int CMD_W   = 4;
    localparam int MODE_W  = 4;
    localparam int PEND_W  = 3;
    localparam int EV_W    = 3;
    localparam int ERR_W   = 3;
    localparam int VAL_W   = 16;
    localparam int CFG_IDX_W = 2;

    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 32;

    typedef logic [MODE_W-1:0] mode_t;
    typedef logic [PEND_W-1:0] pend_t;
    typedef logic [EV_W-1:0]   ev_t;
    typedef logic [ERR_W-1:0]  err_t;
    typedef logic [CMD_W-1:0]  cmd_t;
    typedef logic [VAL_W-1:0]  val_t;

    // commands
    localparam cmd_t CMD_TICK       = 4'd0;
    localparam cmd_t CMD_START      = 4'd1;
    localparam cmd_t CMD_STOP       = 4'd2;
    localparam cmd_t CMD_ACCEPT     = 4'd3;
    localparam cmd_t CMD_REJECT     = 4'd4;
    localparam cmd_t CMD_INSERT     = 4'd5;
    localparam cmd_t CMD_SIMREJECT  = 4'd6;
    localparam cmd_t CMD_JAM        = 4'd7;
    localparam cmd_t CMD_CLEARJAM   = 4'd8;
    localparam cmd_t CMD_FULL       = 4'd9;
    localparam cmd_t CMD_REMOVED    = 4'd10;
    localparam cmd_t CMD_INSERTED   = 4'd11;
    localparam cmd_t CMD_POWERCYCLE = 4'd12;
    localparam cmd_t CMD_CHEAT      = 4'd13;

    // device modes
    localparam mode_t M_DISABLED  = 4'd0;
    localparam mode_t M_POWERUP   = 4'd1;
    localparam mode_t M_IDLE      = 4'd2;
    localparam mode_t M_INTAKE    = 4'd3;
    localparam mode_t M_ESCROWED  = 4'd4;
    localparam mode_t M_STACKING  = 4'd5;
    localparam mode_t M_STACKED   = 4'd6;
    localparam mode_t M_RETURNING = 4'd7;
    localparam mode_t M_RETURNED  = 4'd8;
    localparam mode_t M_REJECTED  = 4'd9;
    localparam mode_t M_JAMMED    = 4'd10;
    localparam mode_t M_FULL      = 4'd11;
    localparam mode_t M_REMOVED   = 4'd12;
    localparam mode_t M_CHEATED   = 4'd13;

    // pending timed transitions
    localparam pend_t P_NONE     = 3'd0;
    localparam pend_t P_IDLE     = 3'd1;
    localparam pend_t P_ESCROW   = 3'd2;
    localparam pend_t P_STACKED  = 3'd3;
    localparam pend_t P_RETURNED = 3'd4;

    // events
    localparam ev_t EV_NONE     = 3'd0;
    localparam ev_t EV_ESCROWED = 3'd1;
    localparam ev_t EV_STACKED  = 3'd2;
    localparam ev_t EV_RETURNED = 3'd3;
    localparam ev_t EV_REJECTED = 3'd4;
    localparam ev_t EV_ERROR    = 3'd5;

    // error codes
    localparam err_t ERR_JAM     = 3'd0;
    localparam err_t ERR_FULL    = 3'd1;
    localparam err_t ERR_REMOVED = 3'd2;
    localparam err_t ERR_POWERUP = 3'd3;
    localparam err_t ERR_CHEATED = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POWERUP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEPTING = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STACKING  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RETURNING = 2'd3;

    localparam val_t SETTLE_TICKS = 16'd200;
    localparam val_t REJECT_TICKS = 16'd300;
    localparam val_t CHEAT_TICKS  = 16'd1000;

    localparam val_t POWERUP_RST   = 16'd2000;
    localparam val_t ACCEPTING_RST = 16'd1000;
    localparam val_t STACKING_RST  = 16'd1000;
    localparam val_t RETURNING_RST = 16'd1000;

endpackage
`default_nettype wire

// ===== hdl/bill_validator_state_machine_core.sv =====
// bill_validator_state_machine_core: banknote validator sequencer, stream in and out
// depends on bvsm_pkg
// result: the result word of an accepted word is registered and valid in the next cycle
// throughput: one word per cycle while m_tready holds; the mode, timer and result are settled in the cycle of
// acceptance and the result register frees as its word is taken in the same cycle
// reset: synchronous active-low aresetn; mode disabled, not connected, nothing pending,
// delays back to 2000/1000/1000/1000, output empty
`default_nettype none
module bill_validator_state_machine_core (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  wire                                   s_tvalid,
    output logic                                  s_tready,
    // cmd [3:0], denomination [19:4], zero [23:20]
    input  wire  [bvsm_pkg::S_DATA_W-1:0]         s_tdata,
    output logic                                  m_tvalid,
    input  wire                                   m_tready,
    // mode [3:0], mode_changed [4], connected [5], connected_changed [6],
    // ready_for_bill [7], event_value [23:8], error_code [26:24], ignored [27], zero [31:28]
    output logic [bvsm_pkg::M_DATA_W-1:0]         m_tdata,
    // event_kind [2:0]
    output logic [bvsm_pkg::EV_W-1:0]             m_tuser,
    input  wire                                   cfg_we,
    input  wire  [bvsm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire  [bvsm_pkg::VAL_W-1:0]            cfg_wdata
);
    import bvsm_pkg::*;

    val_t  powerup_delay_reg, accepting_delay_reg, stacking_delay_reg, returning_delay_reg;
    mode_t mode_reg, mode_next;
    logic  enabled_reg, enabled_next;
    val_t  held_reg, held_next;
    pend_t pend_reg, pend_next;
    val_t  count_reg, count_next;

    logic  m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;
    ev_t   m_user_reg;

    cmd_t  cmd;
    val_t  denom;
    logic  s_accept;
    val_t  count_dec;
    logic  conn_chg, ign;
    ev_t   ev;
    val_t  ev_val;
    err_t  err;

    assign cmd      = s_tdata[CMD_W-1:0];
    assign denom    = s_tdata[CMD_W+VAL_W-1:CMD_W];
    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign count_dec = (count_reg != '0) ? count_reg - 16'd1 : count_reg;

    always_comb begin
        mode_next    = mode_reg;
        enabled_next = enabled_reg;
        held_next    = held_reg;
        pend_next    = pend_reg;
        count_next   = count_reg;
        conn_chg     = 1'b0;
        ign          = 1'b0;
        ev           = EV_NONE;
        ev_val       = '0;
        err          = ERR_JAM;
        case (cmd)
            CMD_TICK: begin
                if (pend_reg != P_NONE) begin
                    count_next = count_dec;
                    if (count_dec == '0) begin
                        pend_next = P_NONE;
                        case (pend_reg)
                            P_IDLE: begin
                                held_next = '0;
                                mode_next = enabled_reg ? M_IDLE : M_DISABLED;
                            end
                            P_ESCROW: begin
                                mode_next = M_ESCROWED;
                                ev        = EV_ESCROWED;
                                ev_val    = held_reg;
                            end
                            P_STACKED: begin
                                mode_next  = M_STACKED;
                                ev         = EV_STACKED;
                                ev_val     = held_reg;
                                pend_next  = P_IDLE;
                                count_next = SETTLE_TICKS;
                            end
                            P_RETURNED: begin
                                mode_next  = M_RETURNED;
                                ev         = EV_RETURNED;
                                pend_next  = P_IDLE;
                                count_next = SETTLE_TICKS;
                            end
                            default: begin
                                pend_next = P_NONE;
                            end
                        endcase
                    end
                end
            end
            CMD_START: begin
                if (enabled_reg) begin
                    ign = 1'b1;
                end else begin
                    enabled_next = 1'b1;
                    conn_chg     = 1'b1;
                    mode_next    = M_POWERUP;
                    pend_next    = P_IDLE;
                    count_next   = powerup_delay_reg;
                end
            end
            CMD_STOP: begin
                enabled_next = 1'b0;
                pend_next    = P_NONE;
                mode_next    = M_DISABLED;
                conn_chg     = 1'b1;
            end
            CMD_ACCEPT: begin
                if (mode_reg != M_ESCROWED) begin
                    ign = 1'b1;
                end else begin
                    mode_next  = M_STACKING;
                    pend_next  = P_STACKED;
                    count_next = stacking_delay_reg;
                end
            end
            CMD_REJECT: begin
                if (mode_reg != M_ESCROWED) begin
                    ign = 1'b1;
                end else begin
                    mode_next  = M_RETURNING;
                    pend_next  = P_RETURNED;
                    count_next = returning_delay_reg;
                end
            end
            CMD_INSERT: begin
                if (!enabled_reg || mode_reg != M_IDLE) begin
                    ign = 1'b1;
                end else begin
                    held_next  = denom;
                    mode_next  = M_INTAKE;
                    pend_next  = P_ESCROW;
                    count_next = accepting_delay_reg;
                end
            end
            CMD_SIMREJECT: begin
                if (mode_reg != M_INTAKE && mode_reg != M_IDLE) begin
                    ign = 1'b1;
                end else begin
                    mode_next  = M_REJECTED;
                    ev         = EV_REJECTED;
                    pend_next  = P_IDLE;
                    count_next = REJECT_TICKS;
                end
            end
            CMD_JAM: begin
                mode_next = M_JAMMED;
                ev        = EV_ERROR;
                err       = ERR_JAM;
            end
            CMD_CLEARJAM: begin
                if (mode_reg != M_JAMMED) begin
                    ign = 1'b1;
                end else begin
                    pend_next = P_NONE;
                    held_next = '0;
                    mode_next = enabled_reg ? M_IDLE : M_DISABLED;
                end
            end
            CMD_FULL: begin
                mode_next = M_FULL;
                ev        = EV_ERROR;
                err       = ERR_FULL;
            end
            CMD_REMOVED: begin
                mode_next = M_REMOVED;
                ev        = EV_ERROR;
                err       = ERR_REMOVED;
            end
            CMD_INSERTED: begin
                if (mode_reg != M_REMOVED && mode_reg != M_FULL) begin
                    ign = 1'b1;
                end else begin
                    pend_next = P_NONE;
                    held_next = '0;
                    mode_next = enabled_reg ? M_IDLE : M_DISABLED;
                end
            end
            CMD_POWERCYCLE: begin
                mode_next  = M_POWERUP;
                ev         = EV_ERROR;
                err        = ERR_POWERUP;
                pend_next  = P_IDLE;
                count_next = powerup_delay_reg;
            end
            CMD_CHEAT: begin
                mode_next  = M_CHEATED;
                ev         = EV_ERROR;
                err        = ERR_CHEATED;
                held_next  = '0;
                pend_next  = P_IDLE;
                count_next = CHEAT_TICKS;
            end
            default: begin
                ign = 1'b1;
            end
        endcase
    end

    always_comb begin
        m_data_next = '0;
        m_data_next[3:0]   = mode_next;
        m_data_next[4]     = (mode_next != mode_reg);
        m_data_next[5]     = enabled_next;
        m_data_next[6]     = conn_chg;
        m_data_next[7]     = enabled_next && (mode_next == M_IDLE);
        m_data_next[23:8]  = ev_val;
        m_data_next[26:24] = err;
        m_data_next[27]    = ign;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            powerup_delay_reg   <= POWERUP_RST;
            accepting_delay_reg <= ACCEPTING_RST;
            stacking_delay_reg  <= STACKING_RST;
            returning_delay_reg <= RETURNING_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_POWERUP:   powerup_delay_reg   <= cfg_wdata;
                REG_ACCEPTING: accepting_delay_reg <= cfg_wdata;
                REG_STACKING:  stacking_delay_reg  <= cfg_wdata;
                REG_RETURNING: returning_delay_reg <= cfg_wdata;
                default: begin
                    powerup_delay_reg <= powerup_delay_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= M_DISABLED;
            enabled_reg <= 1'b0;
            held_reg    <= '0;
            pend_reg    <= P_NONE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                mode_reg    <= mode_next;
                enabled_reg <= enabled_next;
                held_reg    <= held_next;
                pend_reg    <= pend_next;
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_data_reg <= m_data_next;
            m_user_reg <= ev;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // an ignored command leaves the mode alone
    a_ign_no_change: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg[27] |-> !m_data_reg[4])
        else $error("ignored word reports a mode change");

    // ready for bill only when connected and idle
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg[7] |-> m_data_reg[5] && (m_data_reg[3:0] == M_IDLE))
        else $error("ready_for_bill without connected idle");

    // result word mirrors the mode register
    a_mode_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_valid_reg && (m_data_reg[3:0] == mode_reg))
        else $error("result mode differs from state");

    // error code is zero unless the word carries an error event
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_user_reg != EV_ERROR) |-> (m_data_reg[26:24] == ERR_JAM))
        else $error("error code set without error event");

endmodule
`default_nettype wire
